>>> sv/rpbu_pkg.sv
// Package with widths, register indexes and blend mode codes for the pixel blend unit.
`timescale 1ns / 1ps

package rpbu_pkg;

  localparam int unsigned NumCh   = 4;
  localparam int unsigned ChW     = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;

  typedef logic [ChW-1:0] chan_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLEND_MODE  = 2'd0,
    REG_W_PRIMARY   = 2'd1,
    REG_W_SECONDARY = 2'd2,
    REG_W_SLIDE     = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    MODE_ADD     = 4'd0,
    MODE_MIX_A   = 4'd1,
    MODE_MIX_B   = 4'd2,
    MODE_MIX_S   = 4'd3,
    MODE_AVG_A   = 4'd4,
    MODE_MIX_S2  = 4'd5,
    MODE_REPLACE = 4'd6,
    MODE_AVG_B   = 4'd7,
    MODE_AVG_C   = 4'd8,
    MODE_MAX     = 4'd9,
    MODE_MIN     = 4'd10
  } blend_mode_e;

  typedef struct packed {
    chan_t [NumCh-1:0] dest;
    chan_t [NumCh-1:0] src;
  } pix_pair_t;

endpackage

>>> sv/rgba_pixel_blend_unit_core.sv
// Top level of the pixel blend unit: config registers, input register and result register.
// A pixel passes the input register, then the result register; throughput is 1 pixel per cycle
// while out_ready_i does not stall. The per-channel mix (two 8x8 products and a divide by 255
// done as add-and-shift) sits between the input register and the result register.
// Reset: asynchronous active low; clears valids, sets blend_mode to add and all weights to 0.
// The result register is released while the next pixel is taken, so a stall only backs up
// once both stages hold a pixel.
`timescale 1ns / 1ps

module rgba_pixel_blend_unit_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpbu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rpbu_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    dest_ch0_i,
  input  logic [7:0]                    dest_ch1_i,
  input  logic [7:0]                    dest_ch2_i,
  input  logic [7:0]                    dest_ch3_i,
  input  logic [7:0]                    source_ch0_i,
  input  logic [7:0]                    source_ch1_i,
  input  logic [7:0]                    source_ch2_i,
  input  logic [7:0]                    source_ch3_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    mixed_ch0_o,
  output logic [7:0]                    mixed_ch1_o,
  output logic [7:0]                    mixed_ch2_o,
  output logic [7:0]                    mixed_ch3_o
);

  import rpbu_pkg::*;

  blend_mode_e mode_q;
  chan_t       w_primary_q;
  chan_t       w_secondary_q;
  chan_t       w_slide_q;

  logic        in_valid_q;
  pix_pair_t   in_pix_q;
  pix_pair_t   in_pix_d;
  logic        out_valid_q;
  chan_t [NumCh-1:0] res_q;
  chan_t [NumCh-1:0] res_d;

  logic        res_ready;
  chan_t       weight;

  function automatic chan_t div255(input logic [15:0] x);
    logic [16:0] t;
    begin
      t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return t[15:8];
    end
  endfunction

  function automatic chan_t mix8(input chan_t d, input chan_t s, input chan_t a);
    logic [15:0] ps;
    logic [15:0] pd;
    chan_t       sum;
    begin
      ps  = {8'd0, s} * {8'd0, a};
      pd  = {8'd0, d} * {8'd0, ~a};
      sum = div255(ps) + div255(pd);
      return sum;
    end
  endfunction

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_ADD;
      w_primary_q   <= '0;
      w_secondary_q <= '0;
      w_slide_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BLEND_MODE: begin
          if (cfg_wdata_i[3:0] > MODE_MIN) begin
            mode_q <= MODE_MIN;
          end else begin
            mode_q <= blend_mode_e'(cfg_wdata_i[3:0]);
          end
        end
        REG_W_PRIMARY:   w_primary_q   <= cfg_wdata_i;
        REG_W_SECONDARY: w_secondary_q <= cfg_wdata_i;
        REG_W_SLIDE:     w_slide_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign res_ready  = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || res_ready;

  always_comb begin
    in_pix_d.dest = {dest_ch3_i, dest_ch2_i, dest_ch1_i, dest_ch0_i};
    in_pix_d.src  = {source_ch3_i, source_ch2_i, source_ch1_i, source_ch0_i};
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_pix_q <= in_pix_d;
    end
  end

  always_comb begin
    case (mode_q)
      MODE_MIX_A:              weight = w_primary_q;
      MODE_MIX_B:              weight = w_secondary_q;
      MODE_MIX_S, MODE_MIX_S2: weight = w_slide_q;
      default:                 weight = w_slide_q;
    endcase
  end

  always_comb begin
    logic [ChW:0] sum;
    chan_t        d;
    chan_t        s;
    for (int c = 0; c < NumCh; c++) begin
      d   = in_pix_q.dest[c];
      s   = in_pix_q.src[c];
      sum = {1'b0, d} + {1'b0, s};
      case (mode_q) inside
        MODE_ADD:                         res_d[c] = sum[ChW] ? '1 : sum[ChW-1:0];
        MODE_MIX_A, MODE_MIX_B,
        MODE_MIX_S, MODE_MIX_S2:          res_d[c] = mix8(d, s, weight);
        MODE_AVG_A, MODE_AVG_B, MODE_AVG_C: res_d[c] = sum[ChW:1];
        MODE_REPLACE:                     res_d[c] = s;
        MODE_MAX:                         res_d[c] = (d > s) ? d : s;
        default:                          res_d[c] = (d < s) ? d : s;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && res_ready) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mixed_ch0_o = res_q[0];
  assign mixed_ch1_o = res_q[1];
  assign mixed_ch2_o = res_q[2];
  assign mixed_ch3_o = res_q[3];

endmodule
